/* rtl/pqc_pkg.sv */
// Package: field widths, register map, GF(2^8) tables and control types of the P/Q codec.
`timescale 1ns / 1ps
`default_nettype none

package pqc_pkg;

  localparam int UNITS  = 16;
  localparam int UNIT_W = 4;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1B;
  localparam logic [BYTE_W-1:0] GF_GEN      = 8'h03;
  localparam logic [BYTE_W:0]   GF_ORDER    = 9'd255;

  // APB register map
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam logic [1:0] REG_MODE        = 2'd0;
  localparam logic [1:0] REG_LOST_COUNT  = 2'd1;
  localparam logic [1:0] REG_LOST_FIRST  = 2'd2;
  localparam logic [1:0] REG_LOST_SECOND = 2'd3;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_REPAIR = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [1:0]        lost_count;
    logic [UNIT_W-1:0] lost_first;
    logic [UNIT_W-1:0] lost_second;
  } cfg_t;

  // Datapath to controller
  typedef struct packed {
    logic repair;
    logic no_loss;
    logic two;
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic acc;
    logic ld_enc;
    logic ld_one;
    logic ld_pq;
    logic div1;
    logic div2;
    logic div3;
    logic ld_out;
  } cmd_t;

  // Shift-and-add product modulo x^8+x^4+x^3+x+1
  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] x;
    acc = '0;
    x   = a;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) acc = acc ^ x;
      x = x[BYTE_W-1] ? ((x << 1) ^ GF_POLY_LOW) : (x << 1);
    end
    return acc;
  endfunction

  function automatic logic [255:0][BYTE_W-1:0] gf_exp_tab();
    logic [255:0][BYTE_W-1:0] t;
    logic [BYTE_W-1:0]        x;
    x = 8'h01;
    for (int i = 0; i < 256; i++) begin
      t[i] = x;
      x    = gf_mul(x, GF_GEN);
    end
    return t;
  endfunction

  function automatic logic [255:0][BYTE_W-1:0] gf_log_tab();
    logic [255:0][BYTE_W-1:0] e;
    logic [255:0][BYTE_W-1:0] t;
    e = gf_exp_tab();
    t = '0;
    for (int i = 0; i < 255; i++) begin
      t[e[i]] = BYTE_W'(i);
    end
    return t;
  endfunction

  localparam logic [255:0][BYTE_W-1:0] GF_EXP = gf_exp_tab();
  localparam logic [255:0][BYTE_W-1:0] GF_LOG = gf_log_tab();

endpackage

`default_nettype wire

/* rtl/pqc_in_if.sv */
// Interface: input item channel (unit byte of a column plus stored parity).
`timescale 1ns / 1ps
`default_nettype none

interface pqc_in_if import pqc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] unit;
  logic [BYTE_W-1:0] data;
  logic              last;
  logic [BYTE_W-1:0] stored_p;
  logic [BYTE_W-1:0] stored_q;

  modport source (output valid, unit, data, last, stored_p, stored_q, input ready);
  modport sink   (input valid, unit, data, last, stored_p, stored_q, output ready);
endinterface

`default_nettype wire

/* rtl/pqc_out_if.sv */
// Interface: result item channel (parity or rebuilt bytes).
`timescale 1ns / 1ps
`default_nettype none

interface pqc_out_if import pqc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;

  modport source (output valid, first_byte, second_byte, input ready);
  modport sink   (input valid, first_byte, second_byte, output ready);
endinterface

`default_nettype wire

/* rtl/pqc_apb_regs.sv */
// APB configuration registers: mode and lost-unit selection.
`timescale 1ns / 1ps
`default_nettype none

module pqc_apb_regs import pqc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:        cfg_d.mode        = pwdata[0];
        REG_LOST_COUNT:  cfg_d.lost_count  = pwdata[1:0];
        REG_LOST_FIRST:  cfg_d.lost_first  = pwdata[UNIT_W-1:0];
        REG_LOST_SECOND: cfg_d.lost_second = pwdata[UNIT_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode        <= MODE_ENCODE;
      cfg_q.lost_count  <= 2'd0;
      cfg_q.lost_first  <= UNIT_W'(0);
      cfg_q.lost_second <= UNIT_W'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MODE:        prdata[0]          = cfg_q.mode;
      REG_LOST_COUNT:  prdata[1:0]        = cfg_q.lost_count;
      REG_LOST_FIRST:  prdata[UNIT_W-1:0] = cfg_q.lost_first;
      REG_LOST_SECOND: prdata[UNIT_W-1:0] = cfg_q.lost_second;
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/pqc_ctrl.sv */
// Controller: sequences accumulation, the GF division steps and the result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module pqc_ctrl import pqc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_last_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  status_t   status_i,
  output cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV1 = 5'b00010,
    S_DIV2 = 5'b00100,
    S_DIV3 = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   out_free;

  assign out_free   = !ovalid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.acc = 1'b1;
          if (in_last_i) begin
            if (!status_i.repair) begin
              cmd_o.ld_enc = 1'b1;
              state_d      = S_EMIT;
            end else if (status_i.no_loss) begin
              state_d = S_IDLE;
            end else if (status_i.two) begin
              cmd_o.ld_pq = 1'b1;
              state_d     = S_DIV1;
            end else begin
              cmd_o.ld_one = 1'b1;
              state_d      = S_EMIT;
            end
          end
        end
      end
      S_DIV1: begin
        cmd_o.div1 = 1'b1;
        state_d    = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.div2 = 1'b1;
        state_d    = S_DIV3;
      end
      S_DIV3: begin
        cmd_o.div3 = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        // Hold the result until the output register is free
        if (out_free) begin
          cmd_o.ld_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.ld_out)     ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

`default_nettype wire

/* rtl/pqc_datapath.sv */
// Datapath: P/Q accumulators, two-loss solver via log/antilog tables, result registers.
`timescale 1ns / 1ps
`default_nettype none

module pqc_datapath import pqc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  cfg_t                   cfg_i,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  wire logic [UNIT_W-1:0] unit_i,
  input  wire logic [BYTE_W-1:0] data_i,
  input  wire logic              last_i,
  input  wire logic [BYTE_W-1:0] stored_p_i,
  input  wire logic [BYTE_W-1:0] stored_q_i,
  output logic      [BYTE_W-1:0] first_byte_o,
  output logic      [BYTE_W-1:0] second_byte_o
);

  logic [BYTE_W-1:0] p_q, p_d, q_q, q_d;
  logic [BYTE_W-1:0] pp_q, qq_q, num_q, den_q, idx_q;
  logic              numz_q;
  logic [BYTE_W-1:0] res0_q, res1_q;
  logic [BYTE_W-1:0] first_q, second_q;

  logic              skip;
  logic [BYTE_W-1:0] coef, prod, p_new, q_new;
  logic [BYTE_W-1:0] ca, cb, cb_pp, r0;
  logic [BYTE_W:0]   ldiff, lidx;

  // Status for the controller
  assign status_o.repair  = (cfg_i.mode == MODE_REPAIR);
  assign status_o.no_loss = (cfg_i.lost_count == 2'd0);
  assign status_o.two     = cfg_i.lost_count[1] && (cfg_i.lost_first != cfg_i.lost_second);

  // Drop bytes of lost or out-of-range units
  assign skip = (int'(unit_i) >= UNITS) ||
                ((cfg_i.mode == MODE_REPAIR) &&
                 (((cfg_i.lost_count != 2'd0) && (unit_i == cfg_i.lost_first)) ||
                  (cfg_i.lost_count[1] && (unit_i == cfg_i.lost_second))));

  // Multiply-accumulate by the unit coefficient 3^unit
  assign coef  = GF_EXP[{{(BYTE_W-UNIT_W){1'b0}}, unit_i}];
  assign prod  = gf_mul(coef, data_i);
  assign p_new = skip ? p_q : (p_q ^ data_i);
  assign q_new = skip ? q_q : (q_q ^ prod);

  always_comb begin
    p_d = p_q;
    q_d = q_q;
    if (cmd_i.acc) begin
      p_d = last_i ? '0 : p_new;
      q_d = last_i ? '0 : q_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
      q_q <= '0;
    end else begin
      p_q <= p_d;
      q_q <= q_d;
    end
  end

  // Two-loss solve: num = qq ^ cb*pp, den = ca ^ cb, r0 = num / den
  assign ca    = GF_EXP[{{(BYTE_W-UNIT_W){1'b0}}, cfg_i.lost_first}];
  assign cb    = GF_EXP[{{(BYTE_W-UNIT_W){1'b0}}, cfg_i.lost_second}];
  assign cb_pp = gf_mul(cb, pp_q);
  assign ldiff = {1'b0, GF_LOG[num_q]} - {1'b0, GF_LOG[den_q]};
  assign lidx  = ldiff[BYTE_W] ? (ldiff + GF_ORDER) : ldiff;
  assign r0    = numz_q ? '0 : GF_EXP[idx_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_pq) begin
      pp_q <= stored_p_i ^ p_new;
      qq_q <= stored_q_i ^ q_new;
    end
    if (cmd_i.div1) begin
      num_q <= qq_q ^ cb_pp;
      den_q <= ca ^ cb;
    end
    if (cmd_i.div2) begin
      idx_q  <= lidx[BYTE_W-1:0];
      numz_q <= (num_q == '0);
    end
    // Stage the result
    if (cmd_i.ld_enc) begin
      res0_q <= p_new;
      res1_q <= q_new;
    end else if (cmd_i.ld_one) begin
      res0_q <= stored_p_i ^ p_new;
      res1_q <= '0;
    end else if (cmd_i.div3) begin
      res0_q <= r0;
      res1_q <= pp_q ^ r0;
    end
    // Output register
    if (cmd_i.ld_out) begin
      first_q  <= res0_q;
      second_q <= res1_q;
    end
  end

  assign first_byte_o  = first_q;
  assign second_byte_o = second_q;

endmodule

`default_nettype wire

/* rtl/pq_parity_erasure_codec_core.sv */
// Top level: P/Q dual-parity encoder and erasure repair over GF(2^8).
// Throughput: items within a column are taken one per cycle.
// After a column's last item input is held off in S_EMIT (encode, one loss) or in
// S_DIV1, S_DIV2, S_DIV3 and S_EMIT (two losses: product, log difference, antilog), plus
// any wait for the output register. The result shows once S_EMIT loads the output register.
// Reset: asynchronous, active low; clears sums, control state, output valid and config registers.
`timescale 1ns / 1ps
`default_nettype none

module pq_parity_erasure_codec_core import pqc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  pqc_in_if.sink                     in_i,
  pqc_out_if.source                  out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  pqc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pqc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pqc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .status_o      (status),
    .unit_i        (in_i.unit),
    .data_i        (in_i.data),
    .last_i        (in_i.last),
    .stored_p_i    (in_i.stored_p),
    .stored_q_i    (in_i.stored_q),
    .first_byte_o  (out_o.first_byte),
    .second_byte_o (out_o.second_byte)
  );

endmodule

`default_nettype wire

/* rtl/pqc_checker.sv */
// Checker: port-level assertions for the P/Q codec, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pqc_checker import pqc_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_last,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] first_byte,
  input wire logic [BYTE_W-1:0] second_byte
);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result item withdrawn before it was taken");

  // A waiting result keeps its bytes
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(first_byte) && $stable(second_byte))
    else $error("result item changed while stalled");

  // Mid-column items never stall the input
  a_mid_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !in_last |=> in_ready)
    else $error("input held off after a mid-column item");

  // Input is held off only after a column ends
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready) |-> $past(in_valid && in_last))
    else $error("input held off without a last item");

endmodule

bind pq_parity_erasure_codec_core pqc_checker u_pqc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid    (in_i.valid),
  .in_ready    (in_i.ready),
  .in_last     (in_i.last),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .first_byte  (out_o.first_byte),
  .second_byte (out_o.second_byte)
);

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the P/Q parity encoder and erasure repair core.
`timescale 1ns / 1ps

module tb_top;
  import pqc_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 11;
  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int MAX_WAIT      = 18;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int INV_EXP       = 254;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic [BYTE_W-1:0] stored_p;
    logic [BYTE_W-1:0] stored_q;
  } col_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
  } byte_pair_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // APB side
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Item channels
  logic      drv_valid = 1'b0;
  col_item_t drv_item  = '0;
  logic      mon_ready = 1'b0;

  pqc_in_if  in_bus ();
  pqc_out_if out_bus ();

  assign in_bus.valid    = drv_valid;
  assign in_bus.unit     = drv_item.unit;
  assign in_bus.data     = drv_item.data;
  assign in_bus.last     = drv_item.last;
  assign in_bus.stored_p = drv_item.stored_p;
  assign in_bus.stored_q = drv_item.stored_q;
  assign out_bus.ready   = mon_ready;

  pq_parity_erasure_codec_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: register copy and running column sums
  cfg_t              codec_cfg = '{mode: MODE_ENCODE, lost_count: 2'd0,
                                   lost_first: 4'd0, lost_second: 4'd1};
  logic [BYTE_W-1:0] p_acc = '0;
  logic [BYTE_W-1:0] q_acc = '0;

  col_item_t  column_items[$];
  byte_pair_t due_bytes[$];

  int  miss_count  = 0;
  int  cycle_count = 0;
  int  send_wait   = 0;
  int  stall_left  = 0;
  bit  calm_send   = 1'b0;
  bit  calm_recv   = 1'b0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // GF(2^8) product, shift and add modulo x^8+x^4+x^3+x+1
  function automatic logic [BYTE_W-1:0] gf_times(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] acc;
    logic [BYTE_W-1:0] x;
    acc = '0;
    x   = a;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) acc ^= x;
      x = x[BYTE_W-1] ? ((x << 1) ^ GF_POLY_LOW) : (x << 1);
    end
    return acc;
  endfunction

  // Square and multiply over the exponent bits
  function automatic logic [BYTE_W-1:0] gf_power(input logic [BYTE_W-1:0] base,
                                                 input int unsigned ex);
    logic [BYTE_W-1:0] res;
    logic [BYTE_W-1:0] b;
    res = 8'h01;
    b   = base;
    for (int i = 0; i < BYTE_W; i++) begin
      if ((ex >> i) & 1) res = gf_times(res, b);
      b = gf_times(b, b);
    end
    return res;
  endfunction

  // Gap before the next item: none in calm stretches, else a random draw up to MAX_WAIT
  function automatic int draw_wait(input bit calm);
    if (calm) return 0;
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 2);
      default: return $urandom_range(0, MAX_WAIT);
    endcase
  endfunction

  function automatic void report_miss(input bit has_want, input byte_pair_t want,
                                      input byte_pair_t got);
    miss_count++;
    if (miss_count <= MAX_REPORTS) begin
      if (has_want)
        $display("[%0t] result differs: expected first %02h second %02h, got %02h %02h",
                 $realtime, want.first_byte, want.second_byte, got.first_byte,
                 got.second_byte);
      else
        $display("[%0t] result with none due: got first %02h second %02h",
                 $realtime, got.first_byte, got.second_byte);
    end
  endfunction

  // Accumulate one accepted item; queue the column result on its last item
  task automatic parity_repair_step(input col_item_t it);
    int                nlost;
    bit                two;
    bit                skip;
    logic [BYTE_W-1:0] pp;
    logic [BYTE_W-1:0] qq;
    logic [BYTE_W-1:0] ca;
    logic [BYTE_W-1:0] cb;
    logic [BYTE_W-1:0] den;
    byte_pair_t        res;
    nlost = (codec_cfg.lost_count > 2) ? 2 : int'(codec_cfg.lost_count);
    two   = (nlost == 2) && (codec_cfg.lost_first != codec_cfg.lost_second);
    skip  = (int'(it.unit) >= UNITS);
    if (codec_cfg.mode == MODE_REPAIR) begin
      if (nlost >= 1 && it.unit == codec_cfg.lost_first) skip = 1'b1;
      if (nlost == 2 && it.unit == codec_cfg.lost_second) skip = 1'b1;
    end
    if (!skip) begin
      p_acc ^= it.data;
      q_acc ^= gf_times(gf_power(GF_GEN, 32'(it.unit)), it.data);
    end
    if (!it.last) return;
    if (codec_cfg.mode == MODE_ENCODE) begin
      res.first_byte  = p_acc;
      res.second_byte = q_acc;
    end else if (nlost == 0) begin
      // nothing to rebuild: drop the column
      p_acc = '0;
      q_acc = '0;
      return;
    end else begin
      pp  = it.stored_p ^ p_acc;
      qq  = it.stored_q ^ q_acc;
      ca  = gf_power(GF_GEN, 32'(codec_cfg.lost_first));
      cb  = gf_power(GF_GEN, 32'(codec_cfg.lost_second));
      den = ca ^ cb;
      if (two && den != 0) begin
        res.first_byte  = gf_times(qq ^ gf_times(cb, pp), gf_power(den, INV_EXP));
        res.second_byte = pp ^ res.first_byte;
      end else begin
        res.first_byte  = pp;
        res.second_byte = '0;
      end
    end
    p_acc = '0;
    q_acc = '0;
    due_bytes.push_back(res);
  endtask

  // Item driver: present queued items, advance on acceptance
  always @(posedge clk_i) begin : drive_items
    logic vld;
    if (rst_ni) begin
      vld = drv_valid;
      if (drv_valid && in_bus.ready) begin
        parity_repair_step(drv_item);
        vld       = 1'b0;
        send_wait = draw_wait(calm_send);
      end
      if (!vld) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (column_items.size() != 0) begin
          drv_item <= column_items.pop_front();
          vld = 1'b1;
        end
      end
      drv_valid <= vld;
    end
  end

  // Result monitor: check each taken result against the oldest one due
  always @(posedge clk_i) begin : watch_results
    byte_pair_t got;
    byte_pair_t want;
    if (rst_ni) begin
      if (out_bus.valid && mon_ready) begin
        got.first_byte  = out_bus.first_byte;
        got.second_byte = out_bus.second_byte;
        if (due_bytes.size() == 0) begin
          report_miss(1'b0, '0, got);
        end else begin
          want = due_bytes.pop_front();
          if (got.first_byte !== want.first_byte || got.second_byte !== want.second_byte)
            report_miss(1'b1, want, got);
        end
        stall_left = draw_wait(calm_recv);
      end else if (out_bus.valid && stall_left > 0) begin
        stall_left--;
      end
      mon_ready <= (stall_left == 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("pq_parity_erasure_codec_core: mismatch");
      $finish;
    end
  end

  // Two-phase APB write; update the register copy once it lands
  task automatic write_codec_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:        codec_cfg.mode        = val[0];
      REG_LOST_COUNT:  codec_cfg.lost_count  = val[1:0];
      REG_LOST_FIRST:  codec_cfg.lost_first  = val[UNIT_W-1:0];
      REG_LOST_SECOND: codec_cfg.lost_second = val[UNIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_item(input logic [UNIT_W-1:0] u, input logic [BYTE_W-1:0] d,
                           input logic l, input logic [BYTE_W-1:0] sp,
                           input logic [BYTE_W-1:0] sq);
    col_item_t it;
    it.unit     = u;
    it.data     = d;
    it.last     = l;
    it.stored_p = sp;
    it.stored_q = sq;
    column_items.push_back(it);
  endtask

  // Hold until every item is taken and every result is in, then let the
  // block finish any column that gives no result
  task automatic settle();
    while (column_items.size() != 0 || drv_valid || due_bytes.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int                order[UNITS];
    int                random_items;
    int                cols;
    int                n;
    int                j;
    int                tmp;
    bit                noisy;
    bit                cut;
    logic [UNIT_W-1:0] u;
    logic [BYTE_W-1:0] d;
    logic [BYTE_W-1:0] col_p;
    logic [BYTE_W-1:0] col_q;
    logic [UNIT_W-1:0] first_pick;
    logic [1:0]        count_pick;
    random_items = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Encode from reset values: byte extremes, end units, single-item column
    push_item(4'd0, 8'hFF, 1'b0, 8'h00, 8'h00);
    push_item(4'd15, 8'hFF, 1'b0, 8'hFF, 8'hFF);
    push_item(4'd7, 8'h80, 1'b1, 8'h00, 8'h00);
    push_item(4'd15, 8'h00, 1'b1, 8'hFF, 8'hFF);

    // One loss at the top unit; its byte must be dropped
    settle();
    write_codec_reg(REG_MODE, APB_DATA_W'(MODE_REPAIR));
    write_codec_reg(REG_LOST_COUNT, 1);
    write_codec_reg(REG_LOST_FIRST, 15);
    write_codec_reg(REG_LOST_SECOND, 0);
    push_item(4'd0, 8'h01, 1'b0, 8'h00, 8'h00);
    push_item(4'd1, 8'h02, 1'b0, 8'hFF, 8'hFF);
    push_item(4'd15, 8'hAA, 1'b0, 8'h00, 8'h00);
    push_item(4'd2, 8'h04, 1'b0, 8'h00, 8'h00);
    push_item(4'd3, 8'h08, 1'b1, 8'hA5, 8'hC3);

    // Two losses
    settle();
    write_codec_reg(REG_LOST_COUNT, 2);
    write_codec_reg(REG_LOST_FIRST, 2);
    write_codec_reg(REG_LOST_SECOND, 13);
    push_item(4'd0, 8'h5A, 1'b0, 8'h00, 8'h00);
    push_item(4'd1, 8'h3C, 1'b0, 8'h00, 8'h00);
    push_item(4'd13, 8'h77, 1'b0, 8'h00, 8'h00);
    push_item(4'd2, 8'h11, 1'b0, 8'h00, 8'h00);
    push_item(4'd3, 8'hE1, 1'b0, 8'h00, 8'h00);
    push_item(4'd15, 8'h9B, 1'b1, 8'h4D, 8'hF0);

    // Equal lost indices fall back to one loss
    settle();
    write_codec_reg(REG_LOST_SECOND, 2);
    push_item(4'd2, 8'h42, 1'b0, 8'h00, 8'h00);
    push_item(4'd5, 8'h24, 1'b1, 8'hFF, 8'h00);

    // Loss count of three acts as two
    settle();
    write_codec_reg(REG_LOST_COUNT, 3);
    write_codec_reg(REG_LOST_SECOND, 9);
    push_item(4'd9, 8'hC8, 1'b0, 8'h00, 8'h00);
    push_item(4'd4, 8'h6E, 1'b0, 8'h00, 8'h00);
    push_item(4'd2, 8'h19, 1'b1, 8'h00, 8'hFF);

    // Repair with no losses yields nothing
    settle();
    write_codec_reg(REG_LOST_COUNT, 0);
    push_item(4'd6, 8'h33, 1'b0, 8'h00, 8'h00);
    push_item(4'd0, 8'hD2, 1'b1, 8'h12, 8'h34);

    // Change mode mid-column: sums gathered so far carry over
    settle();
    write_codec_reg(REG_MODE, APB_DATA_W'(MODE_ENCODE));
    push_item(4'd1, 8'h81, 1'b0, 8'h00, 8'h00);
    push_item(4'd4, 8'h7F, 1'b0, 8'h00, 8'h00);
    settle();
    write_codec_reg(REG_MODE, APB_DATA_W'(MODE_REPAIR));
    write_codec_reg(REG_LOST_COUNT, 1);
    write_codec_reg(REG_LOST_FIRST, 0);
    push_item(4'd5, 8'hB6, 1'b1, 8'h0F, 8'hF0);

    // Random phases: fresh settings, then stripes, most with true stored parity
    while (random_items < RANDOM_ITEMS) begin
      settle();
      calm_send = ($urandom_range(0, 3) == 0);
      calm_recv = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       count_pick = 2'd0;
        1, 2:    count_pick = 2'd1;
        3, 4:    count_pick = 2'd2;
        default: count_pick = 2'd3;
      endcase
      first_pick = UNIT_W'($urandom_range(0, UNITS - 1));
      write_codec_reg(REG_MODE, ($urandom_range(0, 2) != 0) ? APB_DATA_W'(MODE_REPAIR)
                                                            : APB_DATA_W'(MODE_ENCODE));
      write_codec_reg(REG_LOST_COUNT, APB_DATA_W'(count_pick));
      write_codec_reg(REG_LOST_FIRST, APB_DATA_W'(first_pick));
      write_codec_reg(REG_LOST_SECOND,
                      ($urandom_range(0, 7) == 0) ? APB_DATA_W'(first_pick)
                                                  : $urandom_range(0, UNITS - 1));
      cols = $urandom_range(2, 6);
      for (int c = 0; c < cols; c++) begin
        noisy = ($urandom_range(0, 9) == 0);
        cut   = (c == cols - 1) && ($urandom_range(0, 7) == 0);
        n     = ($urandom_range(0, 4) == 0) ? UNITS : $urandom_range(1, UNITS);
        for (int k = 0; k < UNITS; k++) order[k] = k;
        for (int k = UNITS - 1; k > 0; k--) begin
          j        = $urandom_range(0, k);
          tmp      = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        col_p = '0;
        col_q = '0;
        for (int k = 0; k < n; k++) begin
          u     = noisy ? UNIT_W'($urandom_range(0, UNITS - 1)) : UNIT_W'(order[k]);
          d     = BYTE_W'($urandom_range(0, 255));
          col_p ^= d;
          col_q ^= gf_times(gf_power(GF_GEN, 32'(u)), d);
          if (k == n - 1 && !cut && !noisy)
            push_item(u, d, 1'b1, col_p, col_q);
          else
            push_item(u, d, (k == n - 1) && !cut, BYTE_W'($urandom_range(0, 255)),
                      BYTE_W'($urandom_range(0, 255)));
        end
        random_items += n;
      end
    end

    settle();
    if (miss_count == 0 && due_bytes.size() == 0)
      $display("pq_parity_erasure_codec_core: match");
    else
      $display("pq_parity_erasure_codec_core: mismatch");
    $finish;
  end

endmodule
